// ----- rtl/core/kepq_pkg.sv -----
// shared types, constants and the scancode map of the keyboard event packet queue
package kepq_pkg;

  // field widths
  localparam int unsigned TypeW  = 16;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned EventW = TypeW + CodeW + ValueW;
  localparam int unsigned LeftW  = 7;

  // event codes
  localparam logic [TypeW-1:0] EvSyn     = 16'd0;
  localparam logic [TypeW-1:0] EvKey     = 16'd1;
  localparam logic [TypeW-1:0] EvMsc     = 16'd4;
  localparam logic [CodeW-1:0] MscScan   = 16'd4;
  localparam logic [CodeW-1:0] SynReport = 16'd0;

  // command codes
  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_RAW  = 2'd1,
    CMD_POP  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PUSH_KEY = 2'd1,
    ST_PUSH_SYN = 2'd2,
    ST_POP_OUT  = 2'd3
  } state_e;

  // which event a push writes
  typedef enum logic [1:0] {
    SEL_SCAN = 2'd0,
    SEL_KEY  = 2'd1,
    SEL_SYN  = 2'd2,
    SEL_RAW  = 2'd3
  } push_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      latch_key;
    logic      push;
    push_sel_e push_sel;
    logic      pop;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_mapped;
  } dp_status_t;

  // extended keys: keypad enter, right ctrl, keypad slash, right alt, navigation block, meta and menu
  function automatic logic [6:0] map_extended(input logic [6:0] base);
    logic [6:0] code;
    case (base)
      7'h1C:   code = 7'd96;
      7'h1D:   code = 7'd97;
      7'h35:   code = 7'd98;
      7'h38:   code = 7'd100;
      7'h47:   code = 7'd102;
      7'h48:   code = 7'd103;
      7'h49:   code = 7'd104;
      7'h4B:   code = 7'd105;
      7'h4D:   code = 7'd106;
      7'h4F:   code = 7'd107;
      7'h50:   code = 7'd108;
      7'h51:   code = 7'd109;
      7'h52:   code = 7'd110;
      7'h53:   code = 7'd111;
      7'h5B:   code = 7'd125;
      7'h5C:   code = 7'd126;
      7'h5D:   code = 7'd127;
      default: code = 7'd0;
    endcase
    return code;
  endfunction

  // plain scancodes map to themselves, extended ones (bit 7 set) go through map_extended
  function automatic logic [6:0] map_scancode(input logic [7:0] sc);
    logic [6:0] code;
    if (sc[7]) begin
      code = map_extended(sc[6:0]);
    end else begin
      code = sc[6:0];
    end
    return code;
  endfunction

endpackage

// ----- rtl/core/keyboard_event_packet_queue.sv -----
// top level of the keyboard event packet queue
// key report: busy after acceptance while the key and sync events are written
// (scan event written at the accepting edge, then the key event in ST_PUSH_KEY and
// the sync event in ST_PUSH_SYN, one write port on the ring)
// raw emit and ignored keys: the block stays idle, the next command is taken at once
// pop: result strobed on done_o in the cycle after acceptance, busy while it is shown
// results cannot be stalled; asynchronous active-low reset empties the ring
// and clears the key repeat state, the ring contents need no clearing pass
module keyboard_event_packet_queue
  import kepq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  output logic                     done_o,
  input  logic [1:0]               command_i,
  input  logic [7:0]               key_scancode_i,
  input  logic                     key_state_i,
  input  logic [TypeW-1:0]         event_type_i,
  input  logic [CodeW-1:0]         event_code_i,
  input  logic signed [ValueW-1:0] event_value_i,
  output logic                     out_valid_o,
  output logic [TypeW-1:0]         out_type_o,
  output logic [CodeW-1:0]         out_code_o,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [LeftW-1:0]         entries_left_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer
  kepq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd),
    .busy_o    (busy),
    .done_o    (done_o)
  );

  // ring and result datapath
  kepq_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .key_scancode_i (key_scancode_i),
    .key_state_i    (key_state_i),
    .event_type_i   (event_type_i),
    .event_code_i   (event_code_i),
    .event_value_i  (event_value_i),
    .out_valid_o    (out_valid_o),
    .out_type_o     (out_type_o),
    .out_code_o     (out_code_o),
    .out_value_o    (out_value_o),
    .entries_left_o (entries_left_o)
  );

`ifndef ASSERT_OFF
  // an accepted pop transaction strobes its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_POP) |=> done_o)
    else $error("pop without result strobe");

  // a result is only shown while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // an empty pop carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_valid_o) |-> (out_type_o == '0 && out_code_o == '0
      && out_value_o == '0 && entries_left_o == '0))
    else $error("empty pop with non-zero fields");

  // a raw emit leaves the block ready for the next transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_RAW) |=> !busy)
    else $error("raw emit kept the block busy");

  // pushes never coincide with a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.push && dp_cmd.pop))
    else $error("push and pop in the same cycle");
`endif

endmodule

// ----- rtl/core/kepq_ctrl.sv -----
// command sequencer of the keyboard event packet queue
module kepq_ctrl
  import kepq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] command_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    cmd_o.latch_key = 1'b0;
    cmd_o.push      = 1'b0;
    cmd_o.push_sel  = SEL_SCAN;
    cmd_o.pop       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CMD_KEY: begin
              if (status_i.key_mapped) begin
                cmd_o.latch_key = 1'b1;
                cmd_o.push      = 1'b1;
                cmd_o.push_sel  = SEL_SCAN;
                state_d         = ST_PUSH_KEY;
              end
            end
            CMD_RAW: begin
              cmd_o.push     = 1'b1;
              cmd_o.push_sel = SEL_RAW;
            end
            CMD_POP: begin
              cmd_o.pop = 1'b1;
              state_d   = ST_POP_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_PUSH_KEY: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = SEL_KEY;
        state_d        = ST_PUSH_SYN;
      end
      ST_PUSH_SYN: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = SEL_SYN;
        state_d        = ST_IDLE;
      end
      ST_POP_OUT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_POP_OUT);

endmodule

// ----- rtl/core/kepq_dp.sv -----
// event ring, pointers, key repeat tracking and result registers
module kepq_dp
  import kepq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic [7:0]               key_scancode_i,
  input  logic                     key_state_i,
  input  logic [TypeW-1:0]         event_type_i,
  input  logic [CodeW-1:0]         event_code_i,
  input  logic signed [ValueW-1:0] event_value_i,
  output logic                     out_valid_o,
  output logic [TypeW-1:0]         out_type_o,
  output logic [CodeW-1:0]         out_code_o,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [LeftW-1:0]         entries_left_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(RING_DEPTH);

  logic [EventW-1:0] ring_q [RING_DEPTH];
  logic [PtrW-1:0]   rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              held_q, ext_q;
  logic [6:0]        base_q;
  logic [6:0]        key_code_q;
  logic [1:0]        key_value_q;
  logic [EventW-1:0] rd_data_q;
  logic              hit_q;
  logic [LeftW-1:0]  left_q;

  logic [6:0]        map_code;
  logic              is_repeat;
  logic [1:0]        key_value;
  logic [EventW-1:0] push_data;
  logic              do_write, do_read;
  logic [CntW-1:0]   count_dec;

  // scancode map and repeat detection on the incoming transaction
  assign map_code  = map_scancode(key_scancode_i);
  assign is_repeat = key_state_i && held_q && (ext_q == key_scancode_i[7])
                     && (base_q == key_scancode_i[6:0]);
  assign key_value = is_repeat ? 2'd2 : {1'b0, key_state_i};
  assign status_o.key_mapped = (map_code != 7'd0);

  // latched key event and last key tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      ext_q  <= 1'b0;
      base_q <= 7'd0;
    end else if (cmd_i.latch_key) begin
      if (key_value == 2'd1) begin
        held_q <= 1'b1;
        ext_q  <= key_scancode_i[7];
        base_q <= key_scancode_i[6:0];
      end else if (key_value == 2'd0) begin
        held_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_key) begin
      key_code_q  <= map_code;
      key_value_q <= key_value;
    end
  end

  // event to write
  always_comb begin
    case (cmd_i.push_sel)
      SEL_SCAN: push_data = {EvMsc, MscScan, 24'd0, key_scancode_i};
      SEL_KEY:  push_data = {EvKey, 9'd0, key_code_q, 30'd0, key_value_q};
      SEL_SYN:  push_data = {EvSyn, SynReport, 32'd0};
      SEL_RAW:  push_data = {event_type_i, event_code_i, event_value_i};
      default:  push_data = '0;
    endcase
  end

  // full ring drops, empty ring reads nothing
  assign do_write  = cmd_i.push && (count_q != FullCnt);
  assign do_read   = cmd_i.pop && (count_q != '0);
  assign count_dec = count_q - CntW'(1);

  // ring storage
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      ring_q[wr_ptr_q] <= push_data;
    end
    if (do_read) begin
      rd_data_q <= ring_q[rd_ptr_q];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
        count_q  <= count_q + CntW'(1);
      end
      if (do_read) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
        count_q  <= count_dec;
      end
    end
  end

  // pop result flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      hit_q  <= do_read;
      left_q <= do_read ? LeftW'(count_dec) : '0;
    end
  end

  // an empty pop shows all zeros
  assign out_valid_o    = hit_q;
  assign out_type_o     = hit_q ? rd_data_q[EventW-1 -: TypeW] : '0;
  assign out_code_o     = hit_q ? rd_data_q[ValueW +: CodeW] : '0;
  assign out_value_o    = hit_q ? signed'(rd_data_q[ValueW-1:0]) : '0;
  assign entries_left_o = left_q;

endmodule
